FILE: rtl/fpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpm_pkg
// Shared types and constants for the binary32 multiplier core.
// ----------------------------------------------------------------------------
package fpm_pkg;

  localparam logic [7:0] EXP_MAX  = 8'hFF;
  localparam logic [8:0] EXP_BIAS = 9'd127;
  localparam logic [7:0] EXP_ZERO = 8'h00;
  localparam logic [22:0] QUIET_BIT = 23'h400000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_NORM,
    ST_CHECK,
    ST_SHR,
    ST_RTEST,
    ST_INCR,
    ST_PACK,
    ST_INF,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_LOAD,
    OP_SHL,
    OP_SHR,
    OP_RTEST,
    OP_ROUND,
    OP_PACK,
    OP_PACK_INF
  } op_t;

  typedef struct packed {
    logic special;    // operand pair resolved without arithmetic
    logic top_hi;     // product bit 47
    logic top_lo;     // product bit 46
    logic exp_zero;   // working exponent is zero
    logic exp_neg;    // working exponent bit 8
    logic esum_low;   // e1 + e2 below the bias
    logic round_bit;  // product bit 22
    logic round_cy;   // rounding would carry into bit 47
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/float32_multiplier_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// float32_multiplier_core
// Binary32 multiplier built from a small sequencer and a shared datapath.
// ----------------------------------------------------------------------------
// Usage: raise start with both operands on operand_a and operand_b; the word
// is taken at the clock edge where start is high and busy is low. busy then
// stays high until the product has been delivered.
// The product is marked by done, which is high for a single cycle. The
// receiver cannot stall the block, so it must capture the word in that cycle.
// Special operands (NaN, infinity, zero) pass through latch, load and
// deliver. Ordinary operands pass at least through latch, multiply,
// normalise, check, round test, pack and deliver. A product at or above two
// adds a step for its right shift, each left shift of a small product a
// step, each right shift of an underflowing result a shift and a check, a
// rounding increment an increment step and a rounding carry a further check
// and round test, since a single shift/increment unit does one step per
// cycle. Deep underflow is the worst case. A new word may be offered in the
// cycle after done.
// Reset (rst, synchronous) returns the sequencer to idle; no arithmetic state
// is kept between words, so nothing else needs clearing.
// ----------------------------------------------------------------------------
module float32_multiplier_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  output logic             done,
  output logic [31:0]      product
);

  fpm_pkg::op_t     op;
  fpm_pkg::status_t status;

  // Sequencer: decides the next step from the datapath status flags.
  fpm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .op     (op),
    .busy   (busy),
    .done   (done)
  );

  // Datapath: one multiply, then repeated shift, increment and round steps.
  fpm_datapath u_datapath (
    .clk       (clk),
    .op        (op),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .status    (status),
    .product   (product)
  );

endmodule
`default_nettype wire

FILE: rtl/fpm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpm_datapath
// Operand registers, significand multiplier, shared shift/increment unit and
// the result register.
// ----------------------------------------------------------------------------
module fpm_datapath (
  input  wire logic             clk,
  input  wire fpm_pkg::op_t     op,
  input  wire logic [31:0]      operand_a,
  input  wire logic [31:0]      operand_b,
  output fpm_pkg::status_t      status,
  output logic [31:0]           product
);

  logic [31:0] a_q, b_q;
  logic [47:0] tm;
  logic [8:0]  te;
  logic [8:0]  esum;
  logic [7:0]  rexp;
  logic        sign;

  logic        sa, sb;
  logic [7:0]  ea, eb;
  logic [22:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] ma, mb;
  logic [25:0] rsum;
  logic [47:0] tm_round;
  logic [31:0] special_word;

  always_comb begin
    sa = a_q[31];
    sb = b_q[31];
    ea = a_q[30:23];
    eb = b_q[30:23];
    fa = a_q[22:0];
    fb = b_q[22:0];
    a_nan  = (ea == fpm_pkg::EXP_MAX) && (fa != '0);
    b_nan  = (eb == fpm_pkg::EXP_MAX) && (fb != '0);
    a_inf  = (ea == fpm_pkg::EXP_MAX) && (fa == '0);
    b_inf  = (eb == fpm_pkg::EXP_MAX) && (fb == '0);
    a_zero = (ea == fpm_pkg::EXP_ZERO) && (fa == '0);
    b_zero = (eb == fpm_pkg::EXP_ZERO) && (fb == '0);
    ma = {(ea != fpm_pkg::EXP_ZERO), fa};
    mb = {(eb != fpm_pkg::EXP_ZERO), fb};

    if (a_nan) begin
      special_word = {sa, fpm_pkg::EXP_MAX, fa | fpm_pkg::QUIET_BIT};
    end else if (b_nan) begin
      special_word = {sb, fpm_pkg::EXP_MAX, fb | fpm_pkg::QUIET_BIT};
    end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
      special_word = {1'b1, fpm_pkg::EXP_MAX, fpm_pkg::QUIET_BIT};
    end else if (a_inf || b_inf) begin
      special_word = {sa ^ sb, fpm_pkg::EXP_MAX, 23'd0};
    end else begin
      special_word = {sa ^ sb, fpm_pkg::EXP_ZERO, 23'd0};
    end

    rsum     = tm[47:22] + 26'd1;
    tm_round = {rsum, tm[21:0]};

    status.special   = a_nan || b_nan || a_inf || b_inf || a_zero || b_zero;
    status.top_hi    = tm[47];
    status.top_lo    = tm[46];
    status.exp_zero  = (te == 9'd0);
    status.exp_neg   = te[8];
    status.esum_low  = (esum < fpm_pkg::EXP_BIAS);
    status.round_bit = tm[22];
    status.round_cy  = (tm_round[47:46] == 2'b10);
  end

  always_ff @(posedge clk) begin
    case (op)
      fpm_pkg::OP_LATCH: begin
        a_q <= operand_a;
        b_q <= operand_b;
      end
      fpm_pkg::OP_LOAD: begin
        product <= special_word;
        sign    <= sa ^ sb;
        tm      <= {24'd0, ma} * {24'd0, mb};
        esum    <= 9'({1'b0, ea} + {1'b0, eb});
        te      <= 9'({1'b0, ea} + {1'b0, eb} - fpm_pkg::EXP_BIAS);
      end
      fpm_pkg::OP_SHL: begin
        tm <= {tm[46:0], 1'b0};
        te <= te - 9'd1;
      end
      fpm_pkg::OP_SHR: begin
        tm <= {1'b0, tm[47:1]};
        te <= te + 9'd1;
      end
      fpm_pkg::OP_RTEST: begin
        rexp <= te[7:0];
      end
      fpm_pkg::OP_ROUND: begin
        tm <= tm_round;
        if (tm_round[47:46] == 2'b10) begin
          te <= te + 9'd1;
        end
      end
      fpm_pkg::OP_PACK: begin
        product <= {sign, rexp, tm[45:23]};
      end
      fpm_pkg::OP_PACK_INF: begin
        product <= {sign, fpm_pkg::EXP_MAX, 23'd0};
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/fpm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpm_ctrl
// Sequencer stepping the datapath through multiply, normalise and round.
// ----------------------------------------------------------------------------
module fpm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire fpm_pkg::status_t  status,
  output fpm_pkg::op_t           op,
  output logic                   busy,
  output logic                   done
);

  fpm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fpm_pkg::ST_IDLE: begin
        if (start) state_next = fpm_pkg::ST_LOAD;
      end
      fpm_pkg::ST_LOAD: begin
        state_next = status.special ? fpm_pkg::ST_EMIT : fpm_pkg::ST_NORM;
      end
      fpm_pkg::ST_NORM: begin
        if (status.top_hi) begin
          state_next = fpm_pkg::ST_SHR;
        end else if (!status.top_lo && !status.exp_zero) begin
          state_next = fpm_pkg::ST_NORM;
        end else begin
          state_next = fpm_pkg::ST_CHECK;
        end
      end
      fpm_pkg::ST_CHECK: begin
        if (status.exp_neg) begin
          state_next = status.esum_low ? fpm_pkg::ST_SHR : fpm_pkg::ST_INF;
        end else begin
          state_next = fpm_pkg::ST_RTEST;
        end
      end
      fpm_pkg::ST_SHR:   state_next = fpm_pkg::ST_CHECK;
      fpm_pkg::ST_RTEST: begin
        state_next = status.round_bit ? fpm_pkg::ST_INCR : fpm_pkg::ST_PACK;
      end
      fpm_pkg::ST_INCR: begin
        state_next = status.round_cy ? fpm_pkg::ST_CHECK : fpm_pkg::ST_PACK;
      end
      fpm_pkg::ST_PACK:  state_next = fpm_pkg::ST_EMIT;
      fpm_pkg::ST_INF:   state_next = fpm_pkg::ST_EMIT;
      fpm_pkg::ST_EMIT:  state_next = fpm_pkg::ST_IDLE;
      default:           state_next = fpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op   = fpm_pkg::OP_NONE;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      fpm_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) op = fpm_pkg::OP_LATCH;
      end
      fpm_pkg::ST_LOAD:  op = fpm_pkg::OP_LOAD;
      fpm_pkg::ST_NORM: begin
        if (!status.top_hi && !status.top_lo && !status.exp_zero) op = fpm_pkg::OP_SHL;
      end
      fpm_pkg::ST_SHR:   op = fpm_pkg::OP_SHR;
      fpm_pkg::ST_RTEST: op = fpm_pkg::OP_RTEST;
      fpm_pkg::ST_INCR:  op = fpm_pkg::OP_ROUND;
      fpm_pkg::ST_PACK:  op = fpm_pkg::OP_PACK;
      fpm_pkg::ST_INF:   op = fpm_pkg::OP_PACK_INF;
      fpm_pkg::ST_EMIT:  done = 1'b1;
      default:           op = fpm_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary32 multiplier testbench
// Sends operand pairs to the multiplier core and checks every product against
// a bit-accurate model of its datapath. The model covers NaN, infinity and
// zero handling, denormal operands, wrapping exponent, underflow and overflow.
// ----------------------------------------------------------------------------
module testbench;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  logic        done;
  logic [31:0] product;

  float32_multiplier_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operand_a(operand_a), .operand_b(operand_b),
    .done(done), .product(product)
  );

  // Operand pairs waiting to be offered, and products still to arrive.
  logic [63:0] pending_pairs[$];
  logic [31:0] expected_products[$];

  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned products_seen;
  int unsigned words_sent;
  int unsigned special_sent;
  bit          stimulus_done;
  bit          drain_hold;
  bit          quiet_stretch;

  // The model works through the same steps as the hardware sequencer.
  function automatic logic [31:0] multiply_binary32(input logic [31:0] a,
                                                    input logic [31:0] b);
    logic        sgn;
    logic [7:0]  ea, eb, rexp;
    logic [22:0] fa, fb, rfrac;
    logic [8:0]  esum, te;
    logic [47:0] tm;
    logic [23:0] ma, mb;
    logic [25:0] upper;
    bit          a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    bit          finished, overflow;
    sgn = a[31] ^ b[31];
    ea = a[30:23]; eb = b[30:23];
    fa = a[22:0];  fb = b[22:0];
    a_nan  = (ea == fpm_pkg::EXP_MAX) && (fa != 0);
    b_nan  = (eb == fpm_pkg::EXP_MAX) && (fb != 0);
    a_inf  = (ea == fpm_pkg::EXP_MAX) && (fa == 0);
    b_inf  = (eb == fpm_pkg::EXP_MAX) && (fb == 0);
    a_zero = (ea == fpm_pkg::EXP_ZERO) && (fa == 0);
    b_zero = (eb == fpm_pkg::EXP_ZERO) && (fb == 0);
    if (a_nan) return {a[31], fpm_pkg::EXP_MAX, fa | fpm_pkg::QUIET_BIT};
    if (b_nan) return {b[31], fpm_pkg::EXP_MAX, fb | fpm_pkg::QUIET_BIT};
    if ((a_inf && b_zero) || (a_zero && b_inf))
      return {1'b1, fpm_pkg::EXP_MAX, fpm_pkg::QUIET_BIT};
    if (a_inf || b_inf) return {sgn, fpm_pkg::EXP_MAX, 23'd0};
    if (a_zero || b_zero) return {sgn, fpm_pkg::EXP_ZERO, 23'd0};

    // Denormals keep their stored exponent of zero and get no hidden bit.
    ma = {ea != 0, fa};
    mb = {eb != 0, fb};
    esum = {1'b0, ea} + {1'b0, eb};
    te = esum - fpm_pkg::EXP_BIAS;
    tm = ma * mb;
    rexp = '0;
    overflow = 1'b0;
    finished = 1'b0;
    if (tm[47]) begin
      tm = tm >> 1;
      te = te + 9'd1;
    end else begin
      while (tm[47:46] == 2'b00 && te != 0) begin
        tm = tm << 1;
        te = te - 9'd1;
      end
    end
    while (!finished) begin
      if (te[8]) begin
        // Below the bias the exponent has wrapped: shift right until it
        // comes back round to zero. Above it the result saturates.
        if (esum < fpm_pkg::EXP_BIAS) begin
          tm = tm >> 1;
          te = te + 9'd1;
        end else begin
          overflow = 1'b1;
          finished = 1'b1;
        end
      end else begin
        rexp = te[7:0];
        if (tm[22]) begin
          upper = tm[47:22] + 26'd1;
          tm = {upper, tm[21:0]};
          if (tm[47:46] == 2'b10) te = te + 9'd1;
          else finished = 1'b1;
        end else begin
          finished = 1'b1;
        end
      end
    end
    if (overflow) return {sgn, fpm_pkg::EXP_MAX, 23'd0};
    rfrac = tm[45:23];
    return {sgn, rexp, rfrac};
  endfunction

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = fpm_pkg::EXP_MAX;
      1: v[30:23] = fpm_pkg::EXP_ZERO;
      2: v[30:0] = 31'd0;
      3: begin
        v[30:23] = fpm_pkg::EXP_MAX;
        v[22:0] = '0;
      end
      4: v[30:23] = 8'($urandom_range(1, 20));
      5: v[30:23] = 8'($urandom_range(230, 254));
      default: v[30:23] = 8'($urandom_range(64, 190));
    endcase
    return v;
  endfunction

  task automatic queue_pair(input logic [31:0] a, input logic [31:0] b);
    pending_pairs.push_back({a, b});
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // Directed words first, then random ones.
  initial begin
    queue_pair(32'h3F80_0000, 32'h3F80_0000);  // one times one
    queue_pair(32'h7FC1_2345, 32'h7F80_0001);  // both NaN, first one wins
    queue_pair(32'h3F80_0000, 32'hFF80_0001);  // signalling NaN second
    queue_pair(32'hFFFF_FFFF, 32'h0000_0000);  // NaN with full payload
    queue_pair(32'h7F80_0000, 32'h0000_0000);  // infinity times zero
    queue_pair(32'h8000_0000, 32'hFF80_0000);  // zero times infinity
    queue_pair(32'hFF80_0000, 32'h4000_0000);  // infinity, finite
    queue_pair(32'h8000_0000, 32'h3F80_0000);  // signed zero
    queue_pair(32'h0000_0001, 32'h3F80_0000);  // smallest denormal
    queue_pair(32'h007F_FFFF, 32'h4000_0000);  // largest denormal
    queue_pair(32'h0040_0000, 32'h0040_0000);  // denormal times denormal
    queue_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF);  // overflow
    queue_pair(32'hFF7F_FFFF, 32'h4000_0000);  // overflow by one
    queue_pair(32'h0080_0000, 32'h0080_0000);  // deep underflow
    queue_pair(32'h0080_0000, 32'h3F00_0000);  // shift into denormal range
    queue_pair(32'h3FFF_FFFF, 32'h3FFF_FFFF);  // product at or above two
    queue_pair(32'h3F80_0001, 32'h3FFF_FFFF);  // rounds down just below half
    queue_pair(32'h7F00_0000, 32'h4000_0000);  // exponent reaches 255
    queue_pair(32'h5F80_0000, 32'h5F80_0000);  // exponent exactly 255
    queue_pair(32'h2000_0000, 32'h1F00_0000);  // just below the bias
    queue_pair(32'hAAAA_AAAA, 32'h5555_5555);
    queue_pair(32'h5555_5555, 32'hAAAA_AAAA);
    special_sent = pending_pairs.size();
    repeat (400) queue_pair(random_operand(), random_operand());
  end

  // Driver: offers one word at a time, with random gaps except in a quiet
  // stretch; once it holds off until every product has come back.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      operand_a <= '0;
      operand_b <= '0;
      drain_hold <= 1'b0;
      words_sent <= 0;
      stimulus_done <= 1'b0;
    end else begin
      quiet_stretch = (words_sent >= 100 && words_sent < 180);
      if (start && !busy) begin
        expected_products.push_back(multiply_binary32(operand_a, operand_b));
        words_sent <= words_sent + 1;
        if (words_sent + 1 == 200) drain_hold <= 1'b1;
      end
      if (start && busy) begin
        // The word offered stays put until it is taken.
      end else if (drain_hold) begin
        start <= 1'b0;
        if (expected_products.size() == 0 && !(start && !busy))
          drain_hold <= 1'b0;
      end else if (pending_pairs.size() != 0 &&
                   (quiet_stretch || $urandom_range(0, 99) >= 11)) begin
        {operand_a, operand_b} <= pending_pairs.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
        if (pending_pairs.size() == 0 && !(start && busy)) stimulus_done <= 1'b1;
      end
    end
  end

  // Monitor: every product is checked against the oldest expected word.
  always @(posedge clk) begin
    if (!rst && done) begin
      products_seen <= products_seen + 1;
      if (expected_products.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("Unexpected product %h at cycle %0d", product, cycle_count);
      end else if (expected_products[0] !== product) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("Product mismatch: expected %h, got %h", expected_products[0],
                   product);
        void'(expected_products.pop_front());
      end else begin
        void'(expected_products.pop_front());
      end
    end
  end

  // Finish once everything has drained, or at the cycle limit.
  initial begin
    int unsigned settle;
    cycle_count = 0;
    mismatches = 0;
    products_seen = 0;
    settle = 0;
    while (settle < 600 && cycle_count < 500000) begin
      @(posedge clk);
      cycle_count = cycle_count + 1;
      if (stimulus_done && !start && expected_products.size() == 0)
        settle = settle + 1;
      else
        settle = 0;
    end
    if (cycle_count >= 500000) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
    end else begin
      $display("Run covered %0d words (%0d directed special cases) and %0d products.",
               words_sent, special_sent, products_seen);
      $display("Mismatching products: %0d", mismatches);
      if (mismatches == 0 && expected_products.size() == 0)
        $display("PASSED: all results match");
      else
        $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
